// ----- rtl/core/krtg_pkg.sv -----
package krtg_pkg;

	// Table sizes and the widths that follow from them.
	localparam int USER_SLOTS = 128;
	localparam int GROUP_SLOTS = 128;
	localparam int UIDX_W = $clog2(USER_SLOTS);
	localparam int GIDX_W = $clog2(GROUP_SLOTS);
	localparam int UCNT_W = $clog2(USER_SLOTS + 1);
	localparam int GCNT_W = $clog2(GROUP_SLOTS + 1);
	localparam int SCAN_W = $clog2(((USER_SLOTS > GROUP_SLOTS) ? USER_SLOTS : GROUP_SLOTS) + 1);

	localparam int KEY_W = 32;
	localparam int AGE_W = 8;
	localparam int POS_W = 7;

	// Operation codes.
	localparam logic [2:0] OP_INS_USER = 3'd0;
	localparam logic [2:0] OP_DEL_USER = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_UPS_GROUP = 3'd3;
	localparam logic [2:0] OP_DEL_GROUP = 3'd4;
	localparam logic [2:0] OP_ASSIGN = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NO_USER = 2'd1;
	localparam logic [1:0] ST_NO_GROUP = 2'd2;
	localparam logic [1:0] ST_DUP_FULL = 2'd3;

	// Group key of a user that belongs to no group.
	localparam logic [KEY_W-1:0] NO_GROUP = '1;

	// One row of the user table as it sits in memory.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
		logic [KEY_W-1:0] grp;
	} user_row_t;

	localparam int USER_ROW_W = $bits(user_row_t);

endpackage

// ----- rtl/core/krtg_ram.sv -----
module krtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/keyed_record_table_with_groups_unit.sv -----
// Keyed record table with groups: a user table (key, age, group key) and a
// group table (group key), both kept in insertion order in single-port-write RAMs.
// The input channel (in_valid/in_ready) carries one operation per beat: opcode,
// key, age and group_key. The output channel (out_valid/out_ready) returns one
// result beat per operation: status, row_age, row_group, row_position,
// group_known and group_position.
// An operation is worked by a small sequencer that streams one table entry per
// cycle through a single shared 32-bit key comparator. A scan stops on a match
// or runs past all entries; a delete then moves the later rows up by one; a
// group delete also sweeps the user table once to clear the group from its
// members. An unused opcode goes straight to the result. in_ready is low
// while an operation is in work, so a new beat is taken only after the
// previous result has been loaded into the output register.
// The result sits in an output register, so the next operation is accepted
// while a result still waits; the block holds a finished result until the
// output register is free. Reset empties both tables at once (the counts clear)
// and leaves the output channel idle; no clearing pass is needed.
module keyed_record_table_with_groups_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0]                             opcode,
	input  logic signed [krtg_pkg::KEY_W-1:0]      key,
	input  logic [krtg_pkg::AGE_W-1:0]             age,
	input  logic signed [krtg_pkg::KEY_W-1:0]      group_key,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             status,
	output logic [krtg_pkg::AGE_W-1:0]             row_age,
	output logic signed [krtg_pkg::KEY_W-1:0]      row_group,
	output logic [krtg_pkg::POS_W-1:0]             row_position,
	output logic                                   group_known,
	output logic [krtg_pkg::POS_W-1:0]             group_position
);

	localparam int SW = krtg_pkg::SCAN_W;
	localparam int KW = krtg_pkg::KEY_W;

	// Sequencer phases.
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_USCAN = 3'd1;
	localparam logic [2:0] PH_GSCAN = 3'd2;
	localparam logic [2:0] PH_USHIFT = 3'd3;
	localparam logic [2:0] PH_GSHIFT = 3'd4;
	localparam logic [2:0] PH_UCLEAR = 3'd5;
	localparam logic [2:0] PH_DONE = 3'd6;

	logic [2:0] phase_q;
	logic [krtg_pkg::UCNT_W-1:0] ucount_q;
	logic [krtg_pkg::GCNT_W-1:0] gcount_q;
	logic [SW-1:0] i_q;
	logic v_s1;
	logic [SW-1:0] idx_s1;

	// Operation being worked and the working result.
	logic [2:0] op_q;
	logic [KW-1:0] key_q;
	logic [krtg_pkg::AGE_W-1:0] age_q;
	logic [KW-1:0] gkey_q;
	logic [KW-1:0] target_q;
	krtg_pkg::user_row_t urow_q;
	logic [SW-1:0] upos_q;
	logic [1:0] res_status_q;
	logic [krtg_pkg::AGE_W-1:0] res_age_q;
	logic [KW-1:0] res_group_q;
	logic [SW-1:0] res_pos_q;
	logic res_gknown_q;
	logic [SW-1:0] res_gpos_q;

	// Output register.
	logic out_valid_q;
	logic [1:0] status_q;
	logic [krtg_pkg::AGE_W-1:0] row_age_q;
	logic [KW-1:0] row_group_q;
	logic [krtg_pkg::POS_W-1:0] row_pos_q;
	logic group_known_q;
	logic [krtg_pkg::POS_W-1:0] group_pos_q;

	// Memory ports.
	krtg_pkg::user_row_t urd;
	krtg_pkg::user_row_t u_wdata;
	logic [krtg_pkg::USER_ROW_W-1:0] u_rdata;
	logic u_we;
	logic [krtg_pkg::UIDX_W-1:0] u_waddr;
	logic [KW-1:0] grd;
	logic [KW-1:0] g_wdata;
	logic g_we;
	logic [krtg_pkg::GIDX_W-1:0] g_waddr;

	// Scan control.
	logic scan_user;
	logic [SW-1:0] lim;
	logic issue;
	logic last;
	logic [KW-1:0] cmp_a;
	logic hit;
	logic ufull;
	logic gfull;
	logic [SW-1:0] prev_idx;
	logic [SW-1:0] next_idx;
	logic in_fire;
	logic load_out;
	logic [SW+krtg_pkg::POS_W-1:0] rpos_ext;
	logic [SW+krtg_pkg::POS_W-1:0] gpos_ext;

	assign in_ready = (phase_q == PH_IDLE);
	assign in_fire = in_valid && in_ready;
	assign load_out = (phase_q == PH_DONE) && (!out_valid_q || out_ready);

	assign scan_user = (phase_q == PH_USCAN) || (phase_q == PH_USHIFT) ||
		(phase_q == PH_UCLEAR);
	assign lim = scan_user ? SW'(ucount_q) : SW'(gcount_q);
	assign issue = (i_q < lim);
	assign last = !issue && !v_s1;
	assign ufull = (ucount_q == krtg_pkg::UCNT_W'(krtg_pkg::USER_SLOTS));
	assign gfull = (gcount_q == krtg_pkg::GCNT_W'(krtg_pkg::GROUP_SLOTS));
	assign prev_idx = idx_s1 - SW'(1);
	assign next_idx = idx_s1 + SW'(1);

	// The shared comparator: user key, user group field or group key.
	assign urd = u_rdata;
	always_comb begin
		case (phase_q)
			PH_USCAN: cmp_a = urd.key;
			PH_UCLEAR: cmp_a = urd.grp;
			default: cmp_a = grd;
		endcase
	end
	assign hit = v_s1 && (cmp_a == target_q);

	// User table write port: shift, group clear, insert and assign.
	always_comb begin
		u_we = 1'b0;
		u_waddr = idx_s1[krtg_pkg::UIDX_W-1:0];
		u_wdata = urd;
		case (phase_q)
			PH_USHIFT: begin
				u_we = v_s1;
				u_waddr = prev_idx[krtg_pkg::UIDX_W-1:0];
			end
			PH_UCLEAR: begin
				u_we = hit;
				u_wdata.grp = krtg_pkg::NO_GROUP;
			end
			PH_USCAN: begin
				u_we = (op_q == krtg_pkg::OP_INS_USER) && last && !ufull;
				u_waddr = ucount_q[krtg_pkg::UIDX_W-1:0];
				u_wdata.key = key_q;
				u_wdata.age = age_q;
				u_wdata.grp = gkey_q;
			end
			PH_GSCAN: begin
				u_we = (op_q == krtg_pkg::OP_ASSIGN) && hit;
				u_waddr = upos_q[krtg_pkg::UIDX_W-1:0];
				u_wdata.key = urow_q.key;
				u_wdata.age = urow_q.age;
				u_wdata.grp = gkey_q;
			end
			default: begin
				u_we = 1'b0;
			end
		endcase
	end

	// Group table write port: shift and upsert.
	always_comb begin
		g_we = 1'b0;
		g_waddr = prev_idx[krtg_pkg::GIDX_W-1:0];
		g_wdata = grd;
		case (phase_q)
			PH_GSHIFT: begin
				g_we = v_s1;
			end
			PH_GSCAN: begin
				g_we = (op_q == krtg_pkg::OP_UPS_GROUP) && last && !gfull;
				g_waddr = gcount_q[krtg_pkg::GIDX_W-1:0];
				g_wdata = key_q;
			end
			default: begin
				g_we = 1'b0;
			end
		endcase
	end

	krtg_ram #(
		.WIDTH(krtg_pkg::USER_ROW_W),
		.DEPTH(krtg_pkg::USER_SLOTS)
	) u_user_ram (
		.clk(clk),
		.we(u_we),
		.waddr(u_waddr),
		.wdata(u_wdata),
		.raddr(i_q[krtg_pkg::UIDX_W-1:0]),
		.rdata(u_rdata)
	);

	krtg_ram #(
		.WIDTH(KW),
		.DEPTH(krtg_pkg::GROUP_SLOTS)
	) u_group_ram (
		.clk(clk),
		.we(g_we),
		.waddr(g_waddr),
		.wdata(g_wdata),
		.raddr(i_q[krtg_pkg::GIDX_W-1:0]),
		.rdata(grd)
	);

	// Sequencer, counts and scan pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ucount_q <= '0;
			gcount_q <= '0;
			i_q <= '0;
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
				v_s1 <= issue;
				if (issue) begin
					i_q <= i_q + SW'(1);
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (phase_q)
				PH_IDLE: begin
					if (in_fire) begin
						i_q <= '0;
						v_s1 <= 1'b0;
						case (opcode)
							krtg_pkg::OP_INS_USER, krtg_pkg::OP_DEL_USER,
							krtg_pkg::OP_LOOKUP, krtg_pkg::OP_ASSIGN: phase_q <= PH_USCAN;
							krtg_pkg::OP_UPS_GROUP,
							krtg_pkg::OP_DEL_GROUP: phase_q <= PH_GSCAN;
							default: phase_q <= PH_DONE;
						endcase
					end
				end
				PH_USCAN: begin
					if (hit || last) begin
						v_s1 <= 1'b0;
						i_q <= '0;
						phase_q <= PH_DONE;
						case (op_q)
							krtg_pkg::OP_INS_USER: begin
								if (last && !ufull) begin
									ucount_q <= ucount_q + krtg_pkg::UCNT_W'(1);
								end
							end
							krtg_pkg::OP_DEL_USER: begin
								if (hit) begin
									i_q <= next_idx;
									phase_q <= PH_USHIFT;
								end
							end
							krtg_pkg::OP_LOOKUP, krtg_pkg::OP_ASSIGN: begin
								if (hit) begin
									phase_q <= PH_GSCAN;
								end
							end
							default: phase_q <= PH_DONE;
						endcase
					end
				end
				PH_GSCAN: begin
					if (hit || last) begin
						v_s1 <= 1'b0;
						i_q <= '0;
						phase_q <= PH_DONE;
						case (op_q)
							krtg_pkg::OP_UPS_GROUP: begin
								if (last && !gfull) begin
									gcount_q <= gcount_q + krtg_pkg::GCNT_W'(1);
								end
							end
							krtg_pkg::OP_DEL_GROUP: begin
								if (hit) begin
									i_q <= next_idx;
									phase_q <= PH_GSHIFT;
								end
							end
							default: phase_q <= PH_DONE;
						endcase
					end
				end
				PH_USHIFT: begin
					if (last) begin
						ucount_q <= ucount_q - krtg_pkg::UCNT_W'(1);
						phase_q <= PH_DONE;
					end
				end
				PH_GSHIFT: begin
					if (last) begin
						gcount_q <= gcount_q - krtg_pkg::GCNT_W'(1);
						i_q <= '0;
						phase_q <= PH_UCLEAR;
					end
				end
				PH_UCLEAR: begin
					if (last) begin
						phase_q <= PH_DONE;
					end
				end
				PH_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Operation fields, working result and captured row.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= opcode;
			key_q <= key;
			age_q <= age;
			gkey_q <= group_key;
			target_q <= key;
			res_status_q <= krtg_pkg::ST_DONE;
			res_age_q <= '0;
			res_group_q <= krtg_pkg::NO_GROUP;
			res_pos_q <= '0;
			res_gknown_q <= 1'b0;
			res_gpos_q <= '0;
		end
		case (phase_q)
			PH_USCAN: begin
				if (hit || last) begin
					if (!hit && op_q != krtg_pkg::OP_INS_USER) begin
						res_status_q <= krtg_pkg::ST_NO_USER;
					end
					if (op_q == krtg_pkg::OP_INS_USER && (hit || ufull)) begin
						res_status_q <= krtg_pkg::ST_DUP_FULL;
					end
					urow_q <= urd;
					upos_q <= idx_s1;
					if (op_q == krtg_pkg::OP_LOOKUP && hit) begin
						res_age_q <= urd.age;
						res_group_q <= urd.grp;
						res_pos_q <= idx_s1;
						target_q <= urd.grp;
					end
					if (op_q == krtg_pkg::OP_ASSIGN) begin
						target_q <= gkey_q;
					end
				end
			end
			PH_GSCAN: begin
				if (hit || last) begin
					if (!hit && (op_q == krtg_pkg::OP_DEL_GROUP ||
						op_q == krtg_pkg::OP_ASSIGN)) begin
						res_status_q <= krtg_pkg::ST_NO_GROUP;
					end
					if (op_q == krtg_pkg::OP_LOOKUP && hit) begin
						res_gknown_q <= 1'b1;
						res_gpos_q <= idx_s1;
					end
				end
			end
			default: begin
			end
		endcase
		if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
			idx_s1 <= i_q;
		end
	end

	// Output register: positions carry their low seven bits.
	assign rpos_ext = {{krtg_pkg::POS_W{1'b0}}, res_pos_q};
	assign gpos_ext = {{krtg_pkg::POS_W{1'b0}}, res_gpos_q};
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= res_status_q;
			row_age_q <= res_age_q;
			row_group_q <= res_group_q;
			row_pos_q <= rpos_ext[krtg_pkg::POS_W-1:0];
			group_known_q <= res_gknown_q;
			group_pos_q <= gpos_ext[krtg_pkg::POS_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign row_age = row_age_q;
	assign row_group = row_group_q;
	assign row_position = row_pos_q;
	assign group_known = group_known_q;
	assign group_position = group_pos_q;

endmodule
